FILE: src/btab_pkg.sv
// Shared constants, types and codes of the bilinear table interpolator.
`default_nettype none
package btab_pkg;

  localparam int unsigned MAX_ROWS   = 16;
  localparam int unsigned MAX_COLS   = 16;
  localparam int unsigned ROW_AW     = $clog2(MAX_ROWS);
  localparam int unsigned COL_AW     = $clog2(MAX_COLS);
  localparam int unsigned IDX_W      = (ROW_AW > COL_AW) ? ROW_AW : COL_AW;
  localparam int unsigned GRID_DEPTH = MAX_ROWS * MAX_COLS;
  localparam int unsigned GRID_AW    = $clog2(GRID_DEPTH);

  localparam int unsigned VAL_W      = 32;
  localparam int unsigned CNT_W      = 5;
  localparam int unsigned IN_DATA_W  = 104;
  localparam int unsigned DIV_STEPS  = 48;
  localparam int unsigned DCNT_W     = $clog2(DIV_STEPS);

  // Opcodes carried in the input tuser.
  localparam logic [1:0] OP_LOAD_ROW = 2'd0;
  localparam logic [1:0] OP_LOAD_COL = 2'd1;
  localparam logic [1:0] OP_LOAD_GRID = 2'd2;
  localparam logic [1:0] OP_QUERY    = 2'd3;

  // Result status codes.
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_ZERO_W   = 2'd1;
  localparam logic [1:0] ST_SAT      = 2'd2;

  // Configuration register indexes.
  localparam logic REG_ROWS = 1'b0;
  localparam logic REG_COLS = 1'b1;

  // Operations of the shared arithmetic unit.
  localparam logic ARITH_DIV  = 1'b0;
  localparam logic ARITH_LERP = 1'b1;

  typedef struct packed {
    logic               start;
    logic               op;
    logic signed [32:0] x;   // DIV: numerator, LERP: a
    logic signed [32:0] y;   // DIV: denominator, LERP: b
    logic signed [31:0] z;   // LERP: fraction m
  } arith_cmd_t;

  typedef struct packed {
    logic               done;
    logic signed [31:0] value;
    logic               sat;
  } arith_rsp_t;

endpackage
`default_nettype wire

FILE: src/bilinear_table_interpolator_top.sv
// Top level of the bilinear table interpolator: stream ports, sequencer, tables.
//
// Each input beat is a load or a query, selected by the opcode in
// s_axis_tuser_i. A load writes one row breakpoint, column breakpoint or grid
// value; it returns no beat. A query walks the row axis, then the column
// axis, one breakpoint per cycle, to find the first breakpoint from index 1
// that is not below the point (clamped to the last one in use); forms the
// two Q16.16 fractions with a 48-step bit-serial divider; reads the four
// corner values; and runs three rounded linear steps through the one shared
// arithmetic unit. In order, a query is accepted; per axis, breakpoint 0 is
// fetched and then the breakpoints are visited (1 to 15 on each axis); the
// widths are checked (a zero width skips to the output with a zero-width
// status); two divisions run; the four corners are read; three linear steps
// run; and the output register is loaded. The input is ready only when the
// sequencer is idle. The result sits in an output register, so the next beat
// may be taken while that result waits; a full output register holds the
// sequencer in its last step until the beat is taken. The user must write
// the tables before they are read; the block itself does not enforce this.
// Counts below 2 act as 2, counts above the table size act as the size.
`default_nettype none
module bilinear_table_interpolator_top
  import btab_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic                 cfg_idx_i,
  input  wire logic [CNT_W-1:0]     cfg_data_i,
  input  wire logic                 s_axis_tvalid_i,
  output logic                      s_axis_tready_o,
  // row_index[3:0], col_index[7:4], load_value[39:8],
  // query_row_point[71:40], query_col_point[103:72]
  input  wire logic [IN_DATA_W-1:0] s_axis_tdata_i,
  // opcode[1:0]
  input  wire logic [1:0]           s_axis_tuser_i,
  output logic                      m_axis_tvalid_o,
  input  wire logic                 m_axis_tready_i,
  // interpolated_value[31:0]
  output logic [VAL_W-1:0]          m_axis_tdata_o,
  // status[1:0]
  output logic [1:0]                m_axis_tuser_o
);

  typedef enum logic [10:0] {
    S_IDLE = 11'b00000000001,
    S_LO   = 11'b00000000010,
    S_HI   = 11'b00000000100,
    S_CHK  = 11'b00000001000,
    S_DIV1 = 11'b00000010000,
    S_DIV2 = 11'b00000100000,
    S_GRID = 11'b00001000000,
    S_L1   = 11'b00010000000,
    S_L2   = 11'b00100000000,
    S_L3   = 11'b01000000000,
    S_OUT  = 11'b10000000000
  } state_e;

  function automatic logic [IDX_W-1:0] last_idx(logic [CNT_W-1:0] n, int unsigned mx);
    if (n < CNT_W'(2)) begin
      return IDX_W'(1);
    end
    if (int'(n) > int'(mx)) begin
      return IDX_W'(mx - 1);
    end
    return IDX_W'(n - 1'b1);
  endfunction

  // Input beat fields.
  logic [1:0]         in_op;
  logic [3:0]         in_row;
  logic [3:0]         in_col;
  logic [31:0]        in_val;
  logic [31:0]        in_p;
  logic [31:0]        in_q;
  logic               in_acc;

  assign in_op  = s_axis_tuser_i;
  assign in_row = s_axis_tdata_i[3:0];
  assign in_col = s_axis_tdata_i[7:4];
  assign in_val = s_axis_tdata_i[39:8];
  assign in_p   = s_axis_tdata_i[71:40];
  assign in_q   = s_axis_tdata_i[103:72];

  state_e             state_q, state_d;
  logic [CNT_W-1:0]   rows_q, cols_q;
  logic signed [31:0] p_q, p_d, q_q, q_d;
  logic               axis_col_q, axis_col_d;
  logic [IDX_W-1:0]   idx_q, idx_d;
  logic signed [31:0] lo_q, lo_d;
  logic signed [31:0] xl_q, xl_d, xu_q, xu_d, yl_q, yl_d, yu_q, yu_d;
  logic [IDX_W-1:0]   iu_q, iu_d, ju_q, ju_d;
  logic signed [31:0] m1_q, m1_d, m2_q, m2_d, zl_q, zl_d;
  logic signed [31:0] g_q [4];
  logic [2:0]         gcnt_q, gcnt_d;
  logic               flag_q, flag_d;
  logic signed [31:0] res_val_q, res_val_d;
  logic [1:0]         res_st_q, res_st_d;
  logic               ov_q;
  logic [VAL_W-1:0]   od_q;
  logic [1:0]         os_q;

  arith_cmd_t         cmd;
  arith_rsp_t         rsp;

  logic [IDX_W-1:0]   last_row, last_col, last_cur, rd_idx;
  logic signed [31:0] ax_rdata, row_rdata, col_rdata, grid_rdata, pt_cur;
  logic signed [32:0] dx, dy;
  logic [IDX_W-1:0]   g_row, g_col;
  logic [GRID_AW-1:0] grid_raddr, grid_waddr;
  logic               row_we, col_we, grid_we, out_load;

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;

  // Loads go straight into the tables on the accepting edge.
  assign row_we  = in_acc && (in_op == OP_LOAD_ROW) && (int'(in_row) < int'(MAX_ROWS));
  assign col_we  = in_acc && (in_op == OP_LOAD_COL) && (int'(in_col) < int'(MAX_COLS));
  assign grid_we = in_acc && (in_op == OP_LOAD_GRID) && (int'(in_row) < int'(MAX_ROWS))
                   && (int'(in_col) < int'(MAX_COLS));
  assign grid_waddr = GRID_AW'(int'(in_row) * int'(MAX_COLS) + int'(in_col));

  assign last_row = last_idx(rows_q, MAX_ROWS);
  assign last_col = last_idx(cols_q, MAX_COLS);
  assign last_cur = axis_col_q ? last_col : last_row;
  assign pt_cur   = axis_col_q ? q_q : p_q;
  assign ax_rdata = axis_col_q ? col_rdata : row_rdata;

  assign dx = $signed({xu_q[31], xu_q}) - $signed({xl_q[31], xl_q});
  assign dy = $signed({yu_q[31], yu_q}) - $signed({yl_q[31], yl_q});

  // Corner order: lower row/lower col, lower row/upper col, then upper row.
  assign g_row      = gcnt_q[1] ? iu_q : iu_q - 1'b1;
  assign g_col      = gcnt_q[0] ? ju_q : ju_q - 1'b1;
  assign grid_raddr = GRID_AW'(int'(g_row) * int'(MAX_COLS) + int'(g_col));

  btab_ram #(.WIDTH(VAL_W), .DEPTH(MAX_ROWS)) u_row_ram (
    .clk_i   (clk_i),
    .we_i    (row_we),
    .waddr_i (ROW_AW'(in_row)),
    .wdata_i (in_val),
    .raddr_i (ROW_AW'(rd_idx)),
    .rdata_o (row_rdata)
  );

  btab_ram #(.WIDTH(VAL_W), .DEPTH(MAX_COLS)) u_col_ram (
    .clk_i   (clk_i),
    .we_i    (col_we),
    .waddr_i (COL_AW'(in_col)),
    .wdata_i (in_val),
    .raddr_i (COL_AW'(rd_idx)),
    .rdata_o (col_rdata)
  );

  btab_ram #(.WIDTH(VAL_W), .DEPTH(GRID_DEPTH)) u_grid_ram (
    .clk_i   (clk_i),
    .we_i    (grid_we),
    .waddr_i (grid_waddr),
    .wdata_i (in_val),
    .raddr_i (grid_raddr),
    .rdata_o (grid_rdata)
  );

  btab_arith u_arith (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .rsp_o  (rsp)
  );

  always_comb begin
    state_d    = state_q;
    p_d        = p_q;
    q_d        = q_q;
    axis_col_d = axis_col_q;
    idx_d      = idx_q;
    lo_d       = lo_q;
    xl_d       = xl_q;
    xu_d       = xu_q;
    yl_d       = yl_q;
    yu_d       = yu_q;
    iu_d       = iu_q;
    ju_d       = ju_q;
    m1_d       = m1_q;
    m2_d       = m2_q;
    zl_d       = zl_q;
    gcnt_d     = gcnt_q;
    flag_d     = flag_q;
    res_val_d  = res_val_q;
    res_st_d   = res_st_q;
    rd_idx     = '0;
    out_load   = 1'b0;
    cmd.start  = 1'b0;
    cmd.op     = ARITH_DIV;
    cmd.x      = '0;
    cmd.y      = '0;
    cmd.z      = '0;
    case (state_q)
      S_IDLE: begin
        // Present breakpoint 0 of the row axis so it arrives next cycle.
        if (in_acc && (in_op == OP_QUERY)) begin
          p_d        = in_p;
          q_d        = in_q;
          flag_d     = 1'b0;
          axis_col_d = 1'b0;
          state_d    = S_LO;
        end
      end
      S_LO: begin
        lo_d    = ax_rdata;
        idx_d   = IDX_W'(1);
        rd_idx  = IDX_W'(1);
        state_d = S_HI;
      end
      S_HI: begin
        if ((idx_q == last_cur) || (ax_rdata >= pt_cur)) begin
          if (!axis_col_q) begin
            xl_d       = lo_q;
            xu_d       = ax_rdata;
            iu_d       = idx_q;
            axis_col_d = 1'b1;
            state_d    = S_LO;
          end else begin
            yl_d    = lo_q;
            yu_d    = ax_rdata;
            ju_d    = idx_q;
            state_d = S_CHK;
          end
        end else begin
          // Advance one breakpoint; the read of the next one goes out now.
          lo_d   = ax_rdata;
          idx_d  = idx_q + 1'b1;
          rd_idx = idx_q + 1'b1;
        end
      end
      S_CHK: begin
        if ((dx == '0) || (dy == '0)) begin
          res_val_d = '0;
          res_st_d  = ST_ZERO_W;
          state_d   = S_OUT;
        end else begin
          cmd.start = 1'b1;
          cmd.op    = ARITH_DIV;
          cmd.x     = $signed({p_q[31], p_q}) - $signed({xl_q[31], xl_q});
          cmd.y     = dx;
          state_d   = S_DIV1;
        end
      end
      S_DIV1: begin
        if (rsp.done) begin
          m1_d      = rsp.value;
          flag_d    = flag_q | rsp.sat;
          cmd.start = 1'b1;
          cmd.op    = ARITH_DIV;
          cmd.x     = $signed({q_q[31], q_q}) - $signed({yl_q[31], yl_q});
          cmd.y     = dy;
          state_d   = S_DIV2;
        end
      end
      S_DIV2: begin
        if (rsp.done) begin
          m2_d    = rsp.value;
          flag_d  = flag_q | rsp.sat;
          gcnt_d  = '0;
          state_d = S_GRID;
        end
      end
      S_GRID: begin
        gcnt_d = gcnt_q + 1'b1;
        if (gcnt_q == 3'd4) begin
          cmd.start = 1'b1;
          cmd.op    = ARITH_LERP;
          cmd.x     = {g_q[0][31], g_q[0]};
          cmd.y     = {g_q[1][31], g_q[1]};
          cmd.z     = m2_q;
          state_d   = S_L1;
        end
      end
      S_L1: begin
        if (rsp.done) begin
          zl_d      = rsp.value;
          flag_d    = flag_q | rsp.sat;
          cmd.start = 1'b1;
          cmd.op    = ARITH_LERP;
          cmd.x     = {g_q[2][31], g_q[2]};
          cmd.y     = {g_q[3][31], g_q[3]};
          cmd.z     = m2_q;
          state_d   = S_L2;
        end
      end
      S_L2: begin
        if (rsp.done) begin
          flag_d    = flag_q | rsp.sat;
          cmd.start = 1'b1;
          cmd.op    = ARITH_LERP;
          cmd.x     = {zl_q[31], zl_q};
          cmd.y     = {rsp.value[31], rsp.value};
          cmd.z     = m1_q;
          state_d   = S_L3;
        end
      end
      S_L3: begin
        if (rsp.done) begin
          res_val_d = rsp.value;
          res_st_d  = (flag_q | rsp.sat) ? ST_SAT : ST_OK;
          state_d   = S_OUT;
        end
      end
      S_OUT: begin
        // Hold until the output register is free.
        if (!ov_q || m_axis_tready_i) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      rows_q  <= CNT_W'(16);
      cols_q  <= CNT_W'(16);
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_ROWS: rows_q <= cfg_data_i;
          REG_COLS: cols_q <= cfg_data_i;
          default:  rows_q <= rows_q;
        endcase
      end
      if (out_load) begin
        ov_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        ov_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    p_q        <= p_d;
    q_q        <= q_d;
    axis_col_q <= axis_col_d;
    idx_q      <= idx_d;
    lo_q       <= lo_d;
    xl_q       <= xl_d;
    xu_q       <= xu_d;
    yl_q       <= yl_d;
    yu_q       <= yu_d;
    iu_q       <= iu_d;
    ju_q       <= ju_d;
    m1_q       <= m1_d;
    m2_q       <= m2_d;
    zl_q       <= zl_d;
    gcnt_q     <= gcnt_d;
    flag_q     <= flag_d;
    res_val_q  <= res_val_d;
    res_st_q   <= res_st_d;
    // Corner k arrives in the cycle after its address went out.
    if ((state_q == S_GRID) && (gcnt_q != 3'd0)) begin
      g_q[2'(gcnt_q - 1'b1)] <= grid_rdata;
    end
    if (out_load) begin
      od_q <= res_val_q;
      os_q <= res_st_q;
    end
  end

  assign m_axis_tvalid_o = ov_q;
  assign m_axis_tdata_o  = od_q;
  assign m_axis_tuser_o  = os_q;

endmodule
`default_nettype wire

FILE: src/btab_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module btab_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

FILE: src/btab_arith.sv
// Shared arithmetic unit: bit-serial rounded Q16.16 divide and rounded lerp.
`default_nettype none
module btab_arith
  import btab_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire arith_cmd_t cmd_i,
  output arith_rsp_t      rsp_o
);

  typedef enum logic [4:0] {
    A_IDLE = 5'b00001,
    A_DIV  = 5'b00010,
    A_RND  = 5'b00100,
    A_MUL  = 5'b01000,
    A_ADD  = 5'b10000
  } astate_e;

  astate_e            state_q, state_d;
  logic [DCNT_W-1:0]  cnt_q, cnt_d;
  logic               neg_q, neg_d;
  logic [47:0]        dq_q, dq_d;
  logic [31:0]        rem_q, rem_d;
  logic [31:0]        den_q, den_d;
  logic signed [31:0] a_q, a_d;
  logic signed [32:0] diff_q, diff_d;
  logic signed [31:0] m_q, m_d;
  logic [63:0]        prod_q, prod_d;
  logic signed [31:0] val_q, val_d;
  logic               sat_q, sat_d;
  logic               done_q, done_d;

  logic [31:0]        mag_x, mag_y, mag_m, mag_diff;
  logic [32:0]        rem_sh;
  logic               ge;
  logic [32:0]        rem_sub;
  logic               rnd;
  logic [48:0]        qr;
  logic [64:0]        rsum;
  logic [48:0]        up;
  logic signed [49:0] step;
  logic signed [50:0] sum;

  always_comb begin
    mag_x    = cmd_i.x[32] ? 32'(-cmd_i.x) : cmd_i.x[31:0];
    mag_y    = cmd_i.y[32] ? 32'(-cmd_i.y) : cmd_i.y[31:0];
    mag_m    = m_q[31] ? 32'(-m_q) : m_q;
    mag_diff = diff_q[32] ? 32'(-diff_q) : diff_q[31:0];
    rem_sh   = {rem_q, dq_q[47]};
    ge       = (rem_sh >= {1'b0, den_q});
    rem_sub  = rem_sh - {1'b0, den_q};
    rnd      = ({rem_q, 1'b0} >= {1'b0, den_q});
    qr       = {1'b0, dq_q} + {48'b0, rnd};
    rsum     = {1'b0, prod_q} + 65'd32768;
    up       = rsum[64:16];
    step     = neg_q ? -$signed({1'b0, up}) : $signed({1'b0, up});
    sum      = $signed({{19{a_q[31]}}, a_q}) + $signed({step[49], step});
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    neg_d   = neg_q;
    dq_d    = dq_q;
    rem_d   = rem_q;
    den_d   = den_q;
    a_d     = a_q;
    diff_d  = diff_q;
    m_d     = m_q;
    prod_d  = prod_q;
    val_d   = val_q;
    sat_d   = sat_q;
    done_d  = 1'b0;
    case (state_q)
      A_IDLE: begin
        if (cmd_i.start) begin
          if (cmd_i.op == ARITH_DIV) begin
            neg_d   = cmd_i.x[32] ^ cmd_i.y[32];
            dq_d    = {mag_x, 16'b0};
            rem_d   = '0;
            den_d   = mag_y;
            cnt_d   = '0;
            state_d = A_DIV;
          end else begin
            a_d     = cmd_i.x[31:0];
            diff_d  = cmd_i.y - cmd_i.x;
            m_d     = cmd_i.z;
            state_d = A_MUL;
          end
        end
      end
      A_DIV: begin
        rem_d = ge ? rem_sub[31:0] : rem_sh[31:0];
        dq_d  = {dq_q[46:0], ge};
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == DCNT_W'(DIV_STEPS - 1)) begin
          state_d = A_RND;
        end
      end
      A_RND: begin
        // Round half away from zero, then clamp to the signed 32-bit range.
        if (neg_q) begin
          sat_d = (qr > {17'b0, 32'h8000_0000});
          val_d = sat_d ? 32'sh8000_0000 : 32'(-qr);
        end else begin
          sat_d = (qr > {17'b0, 32'h7fff_ffff});
          val_d = sat_d ? 32'sh7fff_ffff : qr[31:0];
        end
        done_d  = 1'b1;
        state_d = A_IDLE;
      end
      A_MUL: begin
        prod_d  = mag_m * mag_diff;
        neg_d   = m_q[31] ^ diff_q[32];
        state_d = A_ADD;
      end
      A_ADD: begin
        if (sum > 51'sd2147483647) begin
          sat_d = 1'b1;
          val_d = 32'sh7fff_ffff;
        end else if (sum < -51'sd2147483648) begin
          sat_d = 1'b1;
          val_d = 32'sh8000_0000;
        end else begin
          sat_d = 1'b0;
          val_d = sum[31:0];
        end
        done_d  = 1'b1;
        state_d = A_IDLE;
      end
      default: state_d = A_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= A_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q  <= cnt_d;
    neg_q  <= neg_d;
    dq_q   <= dq_d;
    rem_q  <= rem_d;
    den_q  <= den_d;
    a_q    <= a_d;
    diff_q <= diff_d;
    m_q    <= m_d;
    prod_q <= prod_d;
    val_q  <= val_d;
    sat_q  <= sat_d;
  end

  assign rsp_o.done  = done_q;
  assign rsp_o.value = val_q;
  assign rsp_o.sat   = sat_q;

endmodule
`default_nettype wire
